>>> rtl/core/acs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

  localparam int MAX_PARTIALS = 64;
  localparam int PHASE_BITS   = 12;

  localparam int IDX_W    = $clog2(MAX_PARTIALS);
  localparam int FREQ_W   = 24;
  localparam int AMP_W    = 20;
  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 32;
  localparam int NUMP_W   = 7;
  localparam int LOUD_W   = 16;
  // fractional bits of frequency * time (Q16.8 times Q12.20)
  localparam int FRAC_W   = 28;
  localparam int COS_W    = 15;
  localparam int PROD_W   = AMP_W + COS_W;
  localparam int ACC_W    = PROD_W + IDX_W + 1;
  localparam int SCL_W    = ACC_W + LOUD_W + 1;
  localparam int SHIFT    = 24;
  localparam int SH_W     = SCL_W - SHIFT;
  localparam int COS_QTR  = 2 ** (PHASE_BITS - 2);
  localparam int ROM_AW   = PHASE_BITS - 1;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic CFG_NUM_PARTIALS = 1'b0;
  localparam logic CFG_LOUDNESS     = 1'b1;

  localparam logic [NUMP_W-1:0] NUMP_RESET = NUMP_W'(1);
  localparam logic [LOUD_W-1:0] LOUD_RESET = LOUD_W'(4096);

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;

  typedef struct packed {
    logic                    opcode;
    logic [IDX_W-1:0]        partial_index;
    logic [FREQ_W-1:0]       frequency;
    logic [AMP_W-1:0]        intensity;
    logic [TIME_W-1:0]       time_point;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } rsp_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [AMP_W-1:0]  amp;
  } entry_t;

  // per-partial tag that travels down the pipeline
  typedef struct packed {
    logic live;
    logic last;
    logic minus;
  } tok_t;

  typedef logic [COS_W-1:0] cos_rom_t [0:COS_QTR];

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[125:62];
  endfunction

  // round(32767 * cos(pi/2 * p / COS_QTR)) by a Taylor series up to the x^28 term in Q62
  function automatic logic [COS_W-1:0] quarter_cos(input logic [63:0] p);
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] c;
    logic [63:0] prod;
    logic [63:0] rnd;
    mask = 64'(COS_QTR - 1);
    x = (HALF_PI_Q62 >> (PHASE_BITS - 2)) * p
        + (((HALF_PI_Q62 & mask) * p) >> (PHASE_BITS - 2));
    x2 = mul_q62(x, x);
    term = ONE_Q62;
    sum = ONE_Q62;
    for (int k = 1; k <= 14; k++) begin
      term = mul_q62(term, x2) / 64'((2 * k - 1) * (2 * k));
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    c = (sum > ONE_Q62) ? ONE_Q62 : sum;
    prod = (c >> 31) * 64'd32767 + (((c & 64'h7FFFFFFF) * 64'd32767) >> 31);
    rnd = (prod + 64'h40000000) >> 31;
    return rnd[COS_W-1:0];
  endfunction

  function automatic cos_rom_t build_cos_rom();
    cos_rom_t r;
    for (int i = 0; i <= COS_QTR; i++) begin
      r[i] = quarter_cos(64'(i));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/acs_table.sv
`timescale 1ns / 1ps
`default_nettype none

module acs_table (
  input  wire                   clk,
  input  wire                   wr_en,
  input  wire [acs_pkg::IDX_W-1:0] wr_addr,
  input  acs_pkg::entry_t       wr_data,
  input  wire                   rd_en,
  input  wire [acs_pkg::IDX_W-1:0] rd_addr,
  output acs_pkg::entry_t       rd_data
);
  import acs_pkg::*;

  entry_t mem [0:MAX_PARTIALS-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/acs_term.sv
`timescale 1ns / 1ps
`default_nettype none

module acs_term (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  acs_pkg::tok_t              in_tok,
  input  acs_pkg::entry_t            in_entry,
  input  wire [acs_pkg::TIME_W-1:0]  time_point,
  output logic                       out_valid,
  output acs_pkg::tok_t              out_tok,
  output logic [acs_pkg::PROD_W-1:0] out_prod
);
  import acs_pkg::*;

  localparam int CYC_W = FREQ_W + TIME_W;
  localparam int PH_LSB = FRAC_W - PHASE_BITS;
  localparam logic [PHASE_BITS:0] Q1 = (PHASE_BITS + 1)'(COS_QTR);
  localparam logic [PHASE_BITS:0] Q2 = (PHASE_BITS + 1)'(2 * COS_QTR);
  localparam logic [PHASE_BITS:0] Q3 = (PHASE_BITS + 1)'(3 * COS_QTR);
  localparam logic [PHASE_BITS:0] Q4 = (PHASE_BITS + 1)'(4 * COS_QTR);

  localparam cos_rom_t COS_ROM = build_cos_rom();

  logic [CYC_W-1:0]      cyc;
  logic [PHASE_BITS:0]   ph_ext;
  logic [PHASE_BITS:0]   fold;
  logic                  fold_neg;

  // stage 1: phase
  logic                  v1;
  tok_t                  tok1;
  logic [PHASE_BITS-1:0] ph1;
  logic [AMP_W-1:0]      amp1;
  // stage 2: folded quarter-wave address
  logic                  v2;
  tok_t                  tok2;
  logic [ROM_AW-1:0]     addr2;
  logic [AMP_W-1:0]      amp2;
  // stage 3: rom data
  logic                  v3;
  tok_t                  tok3;
  logic [COS_W-1:0]      mag3;
  logic [AMP_W-1:0]      amp3;

  assign cyc = CYC_W'(in_entry.freq) * CYC_W'(time_point);
  assign ph_ext = {1'b0, ph1};

  always_comb begin
    if (ph_ext <= Q1) begin
      fold = ph_ext;
      fold_neg = 1'b0;
    end else if (ph_ext <= Q2) begin
      fold = Q2 - ph_ext;
      fold_neg = 1'b1;
    end else if (ph_ext <= Q3) begin
      fold = ph_ext - Q2;
      fold_neg = 1'b1;
    end else begin
      fold = Q4 - ph_ext;
      fold_neg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    tok1 <= in_tok;
    ph1 <= cyc[PH_LSB +: PHASE_BITS];
    amp1 <= in_entry.amp;

    tok2.live <= tok1.live;
    tok2.last <= tok1.last;
    // negative cosine half flips the add/subtract of this partial
    tok2.minus <= tok1.minus ^ fold_neg;
    addr2 <= fold[ROM_AW-1:0];
    amp2 <= amp1;

    tok3 <= tok2;
    mag3 <= COS_ROM[addr2];
    amp3 <= amp2;

    out_tok <= tok3;
    out_prod <= tok3.live ? PROD_W'(amp3) * PROD_W'(mag3) : '0;
  end

endmodule

`default_nettype wire

>>> rtl/core/acs_mix.sv
`timescale 1ns / 1ps
`default_nettype none

module acs_mix (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  input  acs_pkg::tok_t              in_tok,
  input  wire [acs_pkg::PROD_W-1:0]  in_prod,
  input  wire [acs_pkg::LOUD_W-1:0]  loudness,
  output logic                       res_valid,
  output acs_pkg::rsp_t              res,
  input  wire                        res_take
);
  import acs_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;
  logic                    fin;
  logic                    scl_valid;
  logic signed [SCL_W-1:0] scaled;
  logic signed [SH_W-1:0]  sh;
  logic                    in_range;
  rsp_t                    res_next;

  always_comb begin
    if (in_tok.minus) begin
      acc_next = acc - $signed(ACC_W'(in_prod));
    end else begin
      acc_next = acc + $signed(ACC_W'(in_prod));
    end
  end

  // floor shift is an arithmetic shift of the two's complement product
  assign sh = scaled[SCL_W-1:SHIFT];
  assign in_range = (&sh[SH_W-1:SAMPLE_W-1]) || ~(|sh[SH_W-1:SAMPLE_W-1]);

  always_comb begin
    if (in_range) begin
      res_next.sample = sh[SAMPLE_W-1:0];
      res_next.clipped = 1'b0;
    end else if (sh[SH_W-1]) begin
      res_next.sample = {1'b1, {(SAMPLE_W - 1){1'b0}}};
      res_next.clipped = 1'b1;
    end else begin
      res_next.sample = {1'b0, {(SAMPLE_W - 1){1'b1}}};
      res_next.clipped = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      fin <= 1'b0;
      scl_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      fin <= in_valid && in_tok.last;
      scl_valid <= fin;
      if (fin) begin
        acc <= '0;
      end else if (in_valid) begin
        acc <= acc_next;
      end
      if (scl_valid) begin
        res_valid <= 1'b1;
      end else if (res_take) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      scaled <= SCL_W'(acc) * $signed(SCL_W'({1'b0, loudness}));
    end
    if (scl_valid) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/additive_cosine_synth.sv
// Additive cosine oscillator bank. A load transfer (opcode 0) writes one partial's frequency
// and intensity into the partial table. An evaluate transfer (opcode 1) walks the first N
// table entries one partial per cycle and leaves the result in the output register, where N
// is num_partials capped at 64 (a count of zero still costs one pass and gives a zero
// sample). The walk is paced by the single read port of the partial table; the pipeline
// behind it is: table read, phase multiply, quarter-wave fold, cosine rom, intensity
// multiply, accumulate, gain multiply and saturation. Items are worked one at a time; loads
// and the next evaluate are taken while a finished sample waits in the output register.
// Configuration registers sit at byte address 0 (num_partials) and 4 (loudness) and must be
// written only while idle; the block itself does not enforce this. Table entries that were
// never loaded read as garbage.
`timescale 1ns / 1ps
`default_nettype none

module additive_cosine_synth (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          req_valid,
  output logic                         req_ready,
  input  acs_pkg::req_t                req,
  output logic                         rsp_valid,
  input  wire                          rsp_ready,
  output acs_pkg::rsp_t                rsp,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [acs_pkg::PADDR_W-1:0]   paddr,
  input  wire [acs_pkg::PDATA_W-1:0]   pwdata,
  output logic [acs_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import acs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_WAIT  = 3'b100
  } state_t;

  state_t              state;
  state_t              state_next;

  logic [NUMP_W-1:0]   num_partials;
  logic [LOUD_W-1:0]   loudness;
  logic                cfg_wr;

  logic                req_fire;
  logic                tbl_wr;
  entry_t              tbl_wdata;
  logic                tbl_rd;
  entry_t              tbl_rdata;

  logic [TIME_W-1:0]   time_q;
  logic [IDX_W-1:0]    idx;
  logic [NUMP_W-1:0]   count;
  tok_t                issue_tok;
  logic                rd_valid;
  tok_t                rd_tok;

  logic                term_valid;
  tok_t                term_tok;
  logic [PROD_W-1:0]   term_prod;

  logic                mix_valid;
  rsp_t                mix_res;
  logic                mix_take;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_partials <= NUMP_RESET;
      loudness <= LOUD_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        CFG_NUM_PARTIALS: num_partials <= pwdata[NUMP_W-1:0];
        CFG_LOUDNESS:     loudness <= pwdata[LOUD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CFG_NUM_PARTIALS: prdata = PDATA_W'(num_partials);
      CFG_LOUDNESS:     prdata = PDATA_W'(loudness);
      default:          prdata = '0;
    endcase
  end

  // sequencer
  assign req_ready = (state == ST_IDLE);
  assign req_fire = req_valid && req_ready;
  assign tbl_wr = req_fire && (req.opcode == OP_LOAD);
  assign tbl_wdata.freq = req.frequency;
  assign tbl_wdata.amp = req.intensity;
  assign tbl_rd = (state == ST_ISSUE);

  assign count = (num_partials > NUMP_W'(MAX_PARTIALS)) ? NUMP_W'(MAX_PARTIALS) : num_partials;
  // an empty sum still sends one dead token so the accumulator closes out
  assign issue_tok.live = (count != '0);
  assign issue_tok.last = (count == '0) || ({1'b0, idx} == count - NUMP_W'(1));
  assign issue_tok.minus = idx[0];

  assign mix_take = mix_valid && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire && req.opcode == OP_EVAL) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (issue_tok.last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mix_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
      rd_valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_valid <= tbl_rd;
      if (state == ST_IDLE) begin
        idx <= '0;
      end else if (tbl_rd) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire && req.opcode == OP_EVAL) begin
      time_q <= req.time_point;
    end
    rd_tok <= issue_tok;
  end

  acs_table u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (req.partial_index),
    .wr_data (tbl_wdata),
    .rd_en   (tbl_rd),
    .rd_addr (idx),
    .rd_data (tbl_rdata)
  );

  acs_term u_term (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rd_valid),
    .in_tok     (rd_tok),
    .in_entry   (tbl_rdata),
    .time_point (time_q),
    .out_valid  (term_valid),
    .out_tok    (term_tok),
    .out_prod   (term_prod)
  );

  acs_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (term_valid),
    .in_tok    (term_tok),
    .in_prod   (term_prod),
    .loudness  (loudness),
    .res_valid (mix_valid),
    .res       (mix_res),
    .res_take  (mix_take)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (mix_take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_take) begin
      rsp <= mix_res;
    end
  end

`ifndef SYNTH
  a_ready_no_pending : assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !mix_valid && !term_valid && !rd_valid)
    else $error("new item taken while an evaluation is still in flight");

  a_last_to_wait : assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE && issue_tok.last) |=> (state == ST_WAIT))
    else $error("last partial issued but sequencer did not move to wait");

  a_result_in_wait : assert property (@(posedge clk) disable iff (rst)
    mix_valid |-> (state == ST_WAIT))
    else $error("sample finished outside an evaluation");

  a_no_load_during_eval : assert property (@(posedge clk) disable iff (rst)
    (term_valid || rd_valid) |-> !tbl_wr)
    else $error("table written while partials are being read");
`endif

endmodule

`default_nettype wire

>>> dv/tb_additive_cosine_synth.sv
`timescale 1ns / 1ps

module tb_additive_cosine_synth;
  import acs_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS  = 650;

  localparam int LUT_SIZE  = 2 ** PHASE_BITS;
  localparam int QTR       = LUT_SIZE / 4;
  localparam int QTR_SHIFT = PHASE_BITS - 2;
  localparam int CYC_W     = FREQ_W + TIME_W;

  localparam logic [63:0] PI_HALF_FX = 64'h6487ED5110B4611A;
  localparam logic [63:0] UNITY_FX   = 64'h4000000000000000;

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

  localparam logic [PADDR_W-1:0] NUMP_ADDR = PADDR_W'({CFG_NUM_PARTIALS, 2'b00});
  localparam logic [PADDR_W-1:0] LOUD_ADDR = PADDR_W'({CFG_LOUDNESS, 2'b00});

  localparam logic [FREQ_W-1:0] FREQ_TOP = '1;
  localparam logic [AMP_W-1:0]  AMP_MAX  = '1;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [LOUD_W-1:0] GAIN_MAX = '1;
  localparam logic [FREQ_W-1:0] HZ_1     = FREQ_W'(256);
  localparam logic [FREQ_W-1:0] HZ_2     = FREQ_W'(512);
  localparam logic [TIME_W-1:0] T_QTR    = TIME_W'(1 << 18);
  localparam logic [TIME_W-1:0] T_HALF   = TIME_W'(1 << 19);
  localparam logic [TIME_W-1:0] T_ONE    = TIME_W'(1 << 20);

  typedef enum int {RX_OPEN, RX_COIN, RX_LONG, RX_SPARSE} rx_mode_e;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  req_t                req       = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  rsp_t                rsp;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [PDATA_W-1:0]  pwdata    = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  additive_cosine_synth dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // shadow of the oscillator bank
  int                cos_lut [LUT_SIZE];
  logic [FREQ_W-1:0] freq_mem [MAX_PARTIALS];
  logic [AMP_W-1:0]  amp_mem [MAX_PARTIALS];
  logic [NUMP_W-1:0] cfg_partials = NUMP_RESET;
  logic [LOUD_W-1:0] cfg_gain     = LOUD_RESET;

  bit   loaded [MAX_PARTIALS];
  req_t synth_items [$];
  rsp_t expected_samples [$];
  rsp_t want;

  int issued   = 0;
  int accepted = 0;
  int errors   = 0;

  int       burst_left = 0;
  int       gap_left   = 0;
  int       stall_left = 0;
  int       mode_timer = 0;
  rx_mode_e rx_mode    = RX_OPEN;
  logic     ready_next;

  always #CLK_HALF clk = ~clk;

  function automatic logic [63:0] fx62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] w;
    w = {64'b0, a} * {64'b0, b};
    return w[125:62];
  endfunction

  // quarter-wave cosine scaled to 32767, taylor series in q62
  function automatic int cos_quarter(input int unsigned p);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] prod;
    x = (PI_HALF_FX >> QTR_SHIFT) * 64'(p)
        + (((PI_HALF_FX & 64'(QTR - 1)) * 64'(p)) >> QTR_SHIFT);
    x2 = fx62_mul(x, x);
    term = UNITY_FX;
    acc = UNITY_FX;
    for (int k = 1; k <= 14; k++) begin
      term = fx62_mul(term, x2) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    if (acc > UNITY_FX) acc = UNITY_FX;
    prod = (acc >> 31) * 64'd32767 + (((acc & 64'h7FFF_FFFF) * 64'd32767) >> 31);
    return int'((prod + 64'h4000_0000) >> 31);
  endfunction

  function automatic int active_partials();
    return (cfg_partials > MAX_PARTIALS) ? MAX_PARTIALS : int'(cfg_partials);
  endfunction

  function automatic rsp_t synth_sample(input logic [TIME_W-1:0] t);
    longint            acc;
    longint            term;
    longint            res;
    logic [CYC_W-1:0]  cyc;
    rsp_t              r;
    acc = 0;
    for (int i = 0; i < active_partials(); i++) begin
      cyc = CYC_W'(freq_mem[i]) * CYC_W'(t);
      term = longint'(amp_mem[i]) * longint'(cos_lut[cyc[FRAC_W-1 -: PHASE_BITS]]);
      acc = (i % 2 == 1) ? acc - term : acc + term;
    end
    // arithmetic shift floors toward minus infinity
    res = (acc * longint'(cfg_gain)) >>> SHIFT;
    r.clipped = 1'b0;
    if (res > SAMPLE_MAX) begin
      res = SAMPLE_MAX;
      r.clipped = 1'b1;
    end else if (res < SAMPLE_MIN) begin
      res = SAMPLE_MIN;
      r.clipped = 1'b1;
    end
    r.sample = res[SAMPLE_W-1:0];
    return r;
  endfunction

  task automatic apply_item(input req_t it);
    if (it.opcode == OP_LOAD) begin
      if (int'(it.partial_index) < MAX_PARTIALS) begin
        freq_mem[it.partial_index] = it.frequency;
        amp_mem[it.partial_index] = it.intensity;
      end
    end else begin
      expected_samples.push_back(synth_sample(it.time_point));
    end
  endtask

  // request driver: bursts separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        apply_item(req);
        accepted++;
      end
      if (!req_valid || req_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (synth_items.size() > 0) begin
          req <= synth_items.pop_front();
          req_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: backpressure pattern is redrawn whenever its mode timer runs out
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (mode_timer == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        mode_timer = $urandom_range(50, 300);
      end else begin
        mode_timer--;
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN: begin
            ready_next = 1'b1;
          end
          RX_COIN: begin
            ready_next = ($urandom_range(0, 1) == 1);
          end
          RX_LONG: begin
            ready_next = 1'b1;
            if ($urandom_range(0, 7) == 0) begin
              stall_left = $urandom_range(4, 24);
              ready_next = 1'b0;
            end
          end
          default: begin
            ready_next = ($urandom_range(0, 3) == 0);
          end
        endcase
      end
      rsp_ready <= ready_next;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_samples.size() == 0) begin
        errors++;
        $error("result transfer with nothing expected: sample %0d clipped %0b",
               rsp.sample, rsp.clipped);
      end else begin
        want = expected_samples.pop_front();
        if (rsp.sample !== want.sample) begin
          errors++;
          $error("sample: expected %0d, got %0d", want.sample, rsp.sample);
        end
        if (rsp.clipped !== want.clipped) begin
          errors++;
          $error("clipped: expected %0b, got %0b", want.clipped, rsp.clipped);
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reg_check(input string name, input logic [PADDR_W-1:0] addr,
                           input logic [PDATA_W-1:0] expected);
    logic [PDATA_W-1:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== expected) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, expected, got);
    end
  endtask

  task automatic set_voice(input int n_part, input int gain);
    reg_write(NUMP_ADDR, PDATA_W'(n_part));
    cfg_partials = NUMP_W'(n_part);
    reg_write(LOUD_ADDR, PDATA_W'(gain));
    cfg_gain = LOUD_W'(gain);
    reg_check("num_partials", NUMP_ADDR, PDATA_W'(cfg_partials));
    reg_check("loudness", LOUD_ADDR, PDATA_W'(cfg_gain));
  endtask

  function automatic logic [FREQ_W-1:0] rand_freq();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return FREQ_TOP;
      2: return FREQ_W'($urandom_range(0, 4095));
      default: return FREQ_W'($urandom());
    endcase
  endfunction

  function automatic logic [AMP_W-1:0] rand_amp();
    case ($urandom_range(0, 7))
      0: return '0;
      1, 2: return AMP_MAX;
      default: return AMP_W'($urandom());
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return TIME_MAX;
      2: return T_HALF;
      3: return TIME_W'($urandom_range(0, 1 << 24));
      default: return TIME_W'($urandom());
    endcase
  endfunction

  function automatic int pick_partials();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return MAX_PARTIALS;
      3: return 127;
      4: return $urandom_range(MAX_PARTIALS + 1, 126);
      5: return $urandom_range(9, MAX_PARTIALS - 1);
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return int'(GAIN_MAX);
      2: return int'(LOUD_RESET);
      3: return 1;
      default: return $urandom_range(0, GAIN_MAX);
    endcase
  endfunction

  task automatic push_item(input req_t it);
    synth_items.push_back(it);
    issued++;
  endtask

  task automatic push_load(input int idx, input logic [FREQ_W-1:0] f,
                           input logic [AMP_W-1:0] a);
    req_t it;
    it.opcode = OP_LOAD;
    it.partial_index = IDX_W'(idx);
    it.frequency = f;
    it.intensity = a;
    it.time_point = $urandom();
    loaded[idx] = 1'b1;
    push_item(it);
  endtask

  // never sum an entry that was not loaded since reset
  task automatic push_eval(input logic [TIME_W-1:0] t);
    req_t it;
    for (int i = 0; i < active_partials(); i++) begin
      if (!loaded[i]) push_load(i, rand_freq(), rand_amp());
    end
    it.opcode = OP_EVAL;
    it.partial_index = IDX_W'($urandom());
    it.frequency = FREQ_W'($urandom());
    it.intensity = AMP_W'($urandom());
    it.time_point = t;
    push_item(it);
  endtask

  task automatic settle();
    do @(posedge clk); while (accepted != issued || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n_part;
    int count;
    bit rising;
    int random_base;

    for (int p = 0; p < LUT_SIZE; p++) begin
      if (p <= QTR) begin
        cos_lut[p] = cos_quarter(p);
      end else if (p <= 2 * QTR) begin
        cos_lut[p] = -cos_quarter(2 * QTR - p);
      end else if (p <= 3 * QTR) begin
        cos_lut[p] = -cos_quarter(p - 2 * QTR);
      end else begin
        cos_lut[p] = cos_quarter(4 * QTR - p);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one partial at unity gain
    push_load(0, FREQ_TOP, AMP_MAX);
    push_eval('0);
    push_eval(TIME_MAX);
    push_eval(T_HALF);
    push_load(0, '0, '0);
    push_eval(TIME_MAX);
    push_load(0, HZ_2, AMP_MAX);
    push_load(1, HZ_1, AMP_MAX);
    settle();

    // zero partials sums nothing
    set_voice(0, GAIN_MAX);
    push_eval(TIME_W'($urandom()));
    settle();

    set_voice(2, 0);
    push_eval(T_HALF);
    settle();

    set_voice(2, GAIN_MAX);
    push_eval(T_HALF);
    push_eval(T_QTR);
    push_eval(T_ONE);
    settle();

    random_base = issued;
    while (issued - random_base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        // 1 hz and 2 hz partials at half a second line up in phase and saturate
        n_part = $urandom_range(18, 48);
        rising = ($urandom_range(0, 1) == 1);
        set_voice(n_part, $urandom_range(60000, GAIN_MAX));
        for (int i = 0; i < n_part; i++) begin
          push_load(i, (((i % 2) == 0) == rising) ? HZ_2 : HZ_1, AMP_MAX);
        end
        repeat ($urandom_range(4, 10)) begin
          push_eval(($urandom_range(0, 2) == 0) ? rand_time() : T_HALF);
        end
      end else begin
        set_voice(pick_partials(), pick_gain());
        count = active_partials();
        repeat ($urandom_range(20, 60)) begin
          if ($urandom_range(0, 9) < 4) begin
            push_load((count > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, count - 1)
                                                             : $urandom_range(0, 63),
                      rand_freq(), rand_amp());
          end else begin
            push_eval(rand_time());
          end
        end
      end
      settle();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
